// File: hw/rtl/sqn_pkg.sv
// Shared constants, types and microcode table for the Newton square root block.
`default_nettype none

package sqn_pkg;

   localparam int FRAC_BITS       = 16;
   localparam int DATA_WIDTH      = 32;
   localparam int RADICAND_WIDTH  = 32;
   localparam int DIV_WIDTH       = DATA_WIDTH + FRAC_BITS;
   localparam int ROOT_WIDTH      = 24;
   localparam int TOL_WIDTH       = 16;
   localparam int CAP_WIDTH       = 8;
   localparam int STEP_WIDTH      = CAP_WIDTH + 1;
   localparam int CSR_WIDTH       = 16;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CNT_WIDTH       = $clog2(DIV_WIDTH);
   localparam int PC_WIDTH        = 3;

   localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(1);
   localparam logic [CAP_WIDTH-1:0] CAP_RESET = CAP_WIDTH'(100);

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOLERANCE = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STEP_CAP  = 1'b1;

   typedef logic [PC_WIDTH-1:0] pc_type;

   localparam pc_type PC_WAIT  = 3'd0;
   localparam pc_type PC_DINIT = 3'd1;
   localparam pc_type PC_DSTEP = 3'd2;
   localparam pc_type PC_AVG   = 3'd3;
   localparam pc_type PC_CHECK = 3'd4;
   localparam pc_type PC_EMIT  = 3'd5;

   typedef enum logic [2:0] {
      OP_WAIT,
      OP_DINIT,
      OP_DSTEP,
      OP_AVG,
      OP_CHECK,
      OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      HOLD_NONE,
      HOLD_NO_REQ,
      HOLD_DIV_BUSY,
      HOLD_OUT_FULL
   } hold_type;

   typedef enum logic [1:0] {
      JMP_NEVER,
      JMP_ALWAYS,
      JMP_NONPOS,
      JMP_CONTINUE
   } jmp_type;

   typedef struct packed {
      op_type   op;
      hold_type hold;
      jmp_type  jmp;
      pc_type   target;
   } ucode_type;

   typedef struct packed {
      logic init;
      logic step;
   } div_ctl_type;

   function automatic ucode_type ucode_rom(input pc_type pc);
      ucode_type word;
      unique case (pc)
         PC_WAIT:  word = '{op: OP_WAIT,  hold: HOLD_NO_REQ,   jmp: JMP_NONPOS,   target: PC_EMIT};
         PC_DINIT: word = '{op: OP_DINIT, hold: HOLD_NONE,     jmp: JMP_NEVER,    target: PC_WAIT};
         PC_DSTEP: word = '{op: OP_DSTEP, hold: HOLD_DIV_BUSY, jmp: JMP_NEVER,    target: PC_WAIT};
         PC_AVG:   word = '{op: OP_AVG,   hold: HOLD_NONE,     jmp: JMP_NEVER,    target: PC_WAIT};
         PC_CHECK: word = '{op: OP_CHECK, hold: HOLD_NONE,     jmp: JMP_CONTINUE, target: PC_DINIT};
         PC_EMIT:  word = '{op: OP_EMIT,  hold: HOLD_OUT_FULL, jmp: JMP_ALWAYS,   target: PC_WAIT};
         default:  word = '{op: OP_WAIT,  hold: HOLD_NONE,     jmp: JMP_ALWAYS,   target: PC_WAIT};
      endcase
      return word;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sqn_if.sv
// Request and response channel interfaces of the Newton square root block.
`default_nettype none

interface sqn_req_if;
   logic                                       valid;
   logic                                       ready;
   logic signed [sqn_pkg::RADICAND_WIDTH-1:0]  radicand;

   modport source (output valid, output radicand, input ready);
   modport sink   (input valid, input radicand, output ready);
endinterface

interface sqn_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [sqn_pkg::ROOT_WIDTH-1:0]     root;
   logic                               converged;

   modport source (output valid, output root, output converged, input ready);
   modport sink   (input valid, input root, input converged, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sqn_div.sv
// Restoring divider, one quotient bit per cycle while step is asserted: floor((dividend << FRAC_BITS) / divisor).
`default_nettype none

module sqn_div (
   input  wire                              clock,
   input  wire                              reset,
   input  sqn_pkg::div_ctl_type             ctl,
   input  wire [sqn_pkg::DATA_WIDTH-1:0]    dividend,
   input  wire [sqn_pkg::DIV_WIDTH-1:0]     divisor,
   output logic [sqn_pkg::DIV_WIDTH-1:0]    quotient,
   output logic                             busy
);

   logic [sqn_pkg::DIV_WIDTH-1:0] dvd_ff, dvd_in;
   logic [sqn_pkg::DIV_WIDTH-1:0] rem_ff, rem_in;
   logic [sqn_pkg::DIV_WIDTH-1:0] quo_ff, quo_in;
   logic [sqn_pkg::CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [sqn_pkg::DIV_WIDTH:0]   partial;
   logic [sqn_pkg::DIV_WIDTH:0]   trial;
   logic                          fits;

   assign partial = {rem_ff, dvd_ff[sqn_pkg::DIV_WIDTH-1]};
   assign trial   = partial - {1'b0, divisor};
   assign fits    = ~trial[sqn_pkg::DIV_WIDTH];

   always_comb begin
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (ctl.init) begin
         dvd_in = {dividend, {sqn_pkg::FRAC_BITS{1'b0}}};
         rem_in = '0;
         quo_in = '0;
         cnt_in = sqn_pkg::CNT_WIDTH'(sqn_pkg::DIV_WIDTH - 1);
      end else if (ctl.step) begin
         dvd_in = {dvd_ff[sqn_pkg::DIV_WIDTH-2:0], 1'b0};
         rem_in = fits ? trial[sqn_pkg::DIV_WIDTH-1:0] : partial[sqn_pkg::DIV_WIDTH-1:0];
         quo_in = {quo_ff[sqn_pkg::DIV_WIDTH-2:0], fits};
         if (cnt_ff != '0) begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign quotient = quo_ff;
   assign busy     = (cnt_ff != '0);

endmodule

`default_nettype wire

// File: hw/rtl/square_root_newton.sv
// Top level of the Newton square root block: microcoded sequencer, datapath and registers.
// Takes a signed Q16.16 radicand and returns its unsigned Q8.16 square root by Newton steps
// x <- (x + (S<<16)/x) / 2 starting from x = S. One item is worked at a time. A positive
// radicand runs at most step_cap+1 Newton steps. Each step sets up the bit-serial
// divider, divides at one quotient bit per cycle, then averages and runs the stop test.
// A zero or negative radicand returns 0 with converged set. The result sits in an
// output register; the next radicand is taken while it waits to be read.
// Registers: index 0 is the tolerance in LSBs (reset 1), index 1 the step cap (reset 100).
`default_nettype none

module square_root_newton (
   input  wire                                  clock,
   input  wire                                  reset,
   sqn_req_if.sink                              req_chan,
   sqn_rsp_if.source                            rsp_chan,
   input  wire                                  csr_we,
   input  wire [sqn_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire [sqn_pkg::CSR_WIDTH-1:0]         csr_wdata
);

   logic [sqn_pkg::TOL_WIDTH-1:0]  tol_ff, tol_in;
   logic [sqn_pkg::CAP_WIDTH-1:0]  cap_ff, cap_in;
   sqn_pkg::pc_type                pc_ff, pc_in;
   logic [sqn_pkg::DATA_WIDTH-1:0] s_ff, s_in;
   logic [sqn_pkg::DIV_WIDTH-1:0]  x_ff, x_in;
   logic [sqn_pkg::DIV_WIDTH-1:0]  next_ff, next_in;
   logic [sqn_pkg::STEP_WIDTH-1:0] steps_ff, steps_in;
   logic                           conv_ff, conv_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [sqn_pkg::ROOT_WIDTH-1:0] rsp_root_ff, rsp_root_in;
   logic                           rsp_conv_ff, rsp_conv_in;

   sqn_pkg::ucode_type             uword;
   sqn_pkg::div_ctl_type           div_ctl;
   logic [sqn_pkg::DIV_WIDTH-1:0]  quotient;
   logic                           div_busy;
   logic [sqn_pkg::DATA_WIDTH-1:0] radicand_bits;
   logic                           nonpos;
   logic                           hold;
   logic                           jump;
   logic [sqn_pkg::DIV_WIDTH-1:0]  avg;
   logic [sqn_pkg::DIV_WIDTH-1:0]  change;
   logic                           within_tol;
   logic                           over_cap;
   logic                           stop;
   logic [sqn_pkg::ROOT_WIDTH-1:0] root_sat;

   assign uword = sqn_pkg::ucode_rom(pc_ff);

   assign radicand_bits = req_chan.radicand[sqn_pkg::DATA_WIDTH-1:0];
   assign nonpos = radicand_bits[sqn_pkg::DATA_WIDTH-1] || (radicand_bits == '0);

   assign div_ctl.init = (uword.op == sqn_pkg::OP_DINIT);
   assign div_ctl.step = (uword.op == sqn_pkg::OP_DSTEP);

   sqn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (s_ff),
      .divisor  (x_ff),
      .quotient (quotient),
      .busy     (div_busy)
   );

   assign avg = (x_ff >> 1) + (quotient >> 1)
              + sqn_pkg::DIV_WIDTH'(x_ff[0] & quotient[0]);

   assign change     = (next_ff >= x_ff) ? (next_ff - x_ff) : (x_ff - next_ff);
   assign within_tol = change < sqn_pkg::DIV_WIDTH'(tol_ff);
   assign over_cap   = steps_ff > sqn_pkg::STEP_WIDTH'(cap_ff);
   assign stop       = within_tol || over_cap;

   assign root_sat = (|next_ff[sqn_pkg::DIV_WIDTH-1:sqn_pkg::ROOT_WIDTH])
                   ? {sqn_pkg::ROOT_WIDTH{1'b1}} : next_ff[sqn_pkg::ROOT_WIDTH-1:0];

   always_comb begin
      unique case (uword.hold)
         sqn_pkg::HOLD_NONE:     hold = 1'b0;
         sqn_pkg::HOLD_NO_REQ:   hold = ~req_chan.valid;
         sqn_pkg::HOLD_DIV_BUSY: hold = div_busy;
         sqn_pkg::HOLD_OUT_FULL: hold = rsp_valid_ff && !rsp_chan.ready;
         default:                hold = 1'b0;
      endcase
      unique case (uword.jmp)
         sqn_pkg::JMP_NEVER:    jump = 1'b0;
         sqn_pkg::JMP_ALWAYS:   jump = 1'b1;
         sqn_pkg::JMP_NONPOS:   jump = nonpos;
         sqn_pkg::JMP_CONTINUE: jump = ~stop;
         default:               jump = 1'b0;
      endcase
   end

   always_comb begin
      priority if (hold) begin
         pc_in = pc_ff;
      end else if (jump) begin
         pc_in = uword.target;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   assign req_chan.ready = (uword.op == sqn_pkg::OP_WAIT);

   always_comb begin
      s_in         = s_ff;
      x_in         = x_ff;
      next_in      = next_ff;
      steps_in     = steps_ff;
      conv_in      = conv_ff;
      rsp_root_in  = rsp_root_ff;
      rsp_conv_in  = rsp_conv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      unique case (uword.op)
         sqn_pkg::OP_WAIT: begin
            if (!hold) begin
               s_in     = radicand_bits;
               x_in     = sqn_pkg::DIV_WIDTH'(radicand_bits);
               next_in  = '0;
               steps_in = '0;
               conv_in  = 1'b1;
            end
         end
         sqn_pkg::OP_AVG: begin
            next_in  = avg;
            steps_in = steps_ff + 1'b1;
         end
         sqn_pkg::OP_CHECK: begin
            conv_in = within_tol;
            if (!stop) begin
               x_in = next_ff;
            end
         end
         sqn_pkg::OP_EMIT: begin
            if (!hold) begin
               rsp_valid_in = 1'b1;
               rsp_root_in  = root_sat;
               rsp_conv_in  = conv_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      tol_in = tol_ff;
      cap_in = cap_ff;
      if (csr_we) begin
         unique case (csr_index)
            sqn_pkg::CSR_TOLERANCE: tol_in = csr_wdata[sqn_pkg::TOL_WIDTH-1:0];
            sqn_pkg::CSR_STEP_CAP:  cap_in = csr_wdata[sqn_pkg::CAP_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      s_ff        <= s_in;
      x_ff        <= x_in;
      next_ff     <= next_in;
      rsp_root_ff <= rsp_root_in;
      rsp_conv_ff <= rsp_conv_in;
      if (reset) begin
         tol_ff       <= sqn_pkg::TOL_RESET;
         cap_ff       <= sqn_pkg::CAP_RESET;
         pc_ff        <= sqn_pkg::PC_WAIT;
         steps_ff     <= '0;
         conv_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tol_ff       <= tol_in;
         cap_ff       <= cap_in;
         pc_ff        <= pc_in;
         steps_ff     <= steps_in;
         conv_ff      <= conv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.root      = rsp_root_ff;
   assign rsp_chan.converged = rsp_conv_ff;

`ifndef ASSERT_OFF
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pc_ff == sqn_pkg::PC_EMIT))
      else $error("response beat raised outside the emit step");

   a_cap_bound: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == sqn_pkg::PC_EMIT) && !conv_ff |-> over_cap)
      else $error("unconverged result without reaching the step cap");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (pc_ff != sqn_pkg::PC_WAIT)
      |-> steps_ff <= sqn_pkg::STEP_WIDTH'(cap_ff) + sqn_pkg::STEP_WIDTH'(1))
      else $error("step count ran past the cap");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> rsp_valid_ff && $stable(rsp_root_ff))
      else $error("pending response lost or overwritten");
`endif

endmodule

`default_nettype wire
